// ===== design/srle_pkg.sv =====
// srle_pkg: shared constants and types of the snapshot rle memory decoder
// no dependencies; used by srle_decode and snapshot_rle_memory_decoder
package srle_pkg;

  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 22;
  localparam int unsigned MAX_RESULTS   = 3;
  localparam int unsigned RES_CNT_BITS  = 2;
  localparam int unsigned FIFO_DEPTH    = 4;

  localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_ADDRESS = 2'd1;

  localparam logic [7:0]  ESC_BYTE       = 8'hED;
  localparam logic [15:0] MARKER_LENGTH  = 16'h0000;
  localparam logic [15:0] RAW_MIN        = 16'hC000;
  localparam logic [15:0] RAW_FULL       = 16'hFFFF;
  localparam logic [15:0] RAW_FULL_COUNT = 16'h4000;

  typedef struct packed {
    logic done;
    logic err;
    logic last;
  } res_flags_t;

endpackage

// ===== design/snapshot_rle_memory_decoder.sv =====
// snapshot_rle_memory_decoder: top level, byte decode plus result queue
// depends on srle_pkg and srle_decode
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  in_byte_i
//   out      output     out_valid_o / out_stall_i write_address_o .. last_result_o
//   cfg      input      cfg_we_i                 cfg_index_i, cfg_wdata_i
//
// one byte per cycle is taken unless input stalls; its results go into a four-entry queue the same cycle
// results leave at one per cycle unless out_stall_i is high, so a byte with three
// results holds input back; input stalls while the queue holds two or more results
// reset clears the registers, the decode state and the queue
module snapshot_rle_memory_decoder #(
  parameter int unsigned ADDRESS_BITS = 22,
  parameter int unsigned PAGE_BITS    = 14
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [srle_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [srle_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         in_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ADDRESS_BITS-1:0]            write_address_o,
  output logic [7:0]                         write_value_o,
  output logic [7:0]                         run_length_o,
  output logic                               block_done_o,
  output logic                               format_error_o,
  output logic                               last_result_o
);

  localparam int unsigned DEPTH    = srle_pkg::FIFO_DEPTH;
  localparam int unsigned PTR_BITS = $clog2(DEPTH);
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
  localparam int unsigned NRES     = srle_pkg::MAX_RESULTS;

  logic                                   accept, pop;
  logic [srle_pkg::RES_CNT_BITS-1:0]      res_cnt;
  logic [NRES-1:0][ADDRESS_BITS-1:0]      res_addr;
  logic [NRES-1:0][7:0]                   res_value;
  logic [NRES-1:0][7:0]                   res_len;
  srle_pkg::res_flags_t [NRES-1:0]        res_flags;

  logic [ADDRESS_BITS-1:0]    addr_q  [DEPTH];
  logic [7:0]                 value_q [DEPTH];
  logic [7:0]                 len_q   [DEPTH];
  srle_pkg::res_flags_t       flags_q [DEPTH];
  logic [PTR_BITS-1:0]        wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0]        cnt_q, cnt_d;
  logic [CNT_BITS-1:0]        push_n;
  logic [PTR_BITS-1:0]        slot;

  srle_decode #(
    .ADDRESS_BITS(ADDRESS_BITS),
    .PAGE_BITS   (PAGE_BITS)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .step_i     (accept),
    .in_byte_i  (in_byte_i),
    .res_cnt_o  (res_cnt),
    .res_addr_o (res_addr),
    .res_value_o(res_value),
    .res_len_o  (res_len),
    .res_flags_o(res_flags)
  );

  assign in_stall_o  = (cnt_q > CNT_BITS'(DEPTH - NRES));
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign push_n      = accept ? CNT_BITS'(res_cnt) : '0;
  assign cnt_d       = cnt_q + push_n - (pop ? CNT_BITS'(1) : '0);

  assign write_address_o = addr_q[rd_ptr_q];
  assign write_value_o   = value_q[rd_ptr_q];
  assign run_length_o    = len_q[rd_ptr_q];
  assign block_done_o    = flags_q[rd_ptr_q].done;
  assign format_error_o  = flags_q[rd_ptr_q].err;
  assign last_result_o   = flags_q[rd_ptr_q].last;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NRES; k++) begin
      if (CNT_BITS'(k) < push_n) begin
        addr_q[wr_ptr_q + PTR_BITS'(k)]  <= res_addr[k];
        value_q[wr_ptr_q + PTR_BITS'(k)] <= res_value[k];
        len_q[wr_ptr_q + PTR_BITS'(k)]   <= res_len[k];
        flags_q[wr_ptr_q + PTR_BITS'(k)] <= res_flags[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_BITS'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  assign slot = rd_ptr_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(DEPTH))
    else $error("result queue overflow");

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (CNT_BITS'(res_cnt) + cnt_q <= CNT_BITS'(DEPTH)))
    else $error("item results do not fit the queue");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (block_done_o || format_error_o)) |-> last_result_o)
    else $error("status flag on a result that is not the last of its item");

  a_hold_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (slot == $past(slot) && out_valid_o))
    else $error("queue head moved while stalled");

endmodule

// ===== design/srle_decode.sv =====
// srle_decode: configuration registers, token state and per-byte decode
// gives up to three write runs for the byte on in_byte_i; uses srle_pkg
module srle_decode #(
  parameter int unsigned ADDRESS_BITS = 22,
  parameter int unsigned PAGE_BITS    = 14
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [srle_pkg::CFG_IDX_BITS-1:0]         cfg_index_i,
  input  logic [srle_pkg::CFG_DATA_BITS-1:0]        cfg_wdata_i,
  input  logic                                      step_i,
  input  logic [7:0]                                in_byte_i,
  output logic [srle_pkg::RES_CNT_BITS-1:0]         res_cnt_o,
  output logic [srle_pkg::MAX_RESULTS-1:0][ADDRESS_BITS-1:0] res_addr_o,
  output logic [srle_pkg::MAX_RESULTS-1:0][7:0]     res_value_o,
  output logic [srle_pkg::MAX_RESULTS-1:0][7:0]     res_len_o,
  output srle_pkg::res_flags_t [srle_pkg::MAX_RESULTS-1:0] res_flags_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_Z,
    PH_Z_E,
    PH_Z_E_E,
    PH_E,
    PH_E_E,
    PH_CNT
  } phase_e;

  localparam int unsigned EXT_BITS = (ADDRESS_BITS > srle_pkg::CFG_DATA_BITS) ?
                                     ADDRESS_BITS : srle_pkg::CFG_DATA_BITS;
  localparam int unsigned RES_CNT_BITS_L = srle_pkg::RES_CNT_BITS;

  logic [15:0]             block_length_q;
  logic [ADDRESS_BITS-1:0] start_address_q;
  phase_e                  phase_q, phase_d;
  logic [ADDRESS_BITS-1:0] next_addr_q, next_addr_d;
  logic [15:0]             consumed_q, consumed_d;
  logic [7:0]              pending_q, pending_d;
  logic                    halted_q;

  logic [EXT_BITS-1:0]     cfg_ext;
  logic [ADDRESS_BITS-1:0] cfg_start;

  logic                    marker, raw, at_end;
  logic [15:0]             raw_total;
  logic                    pre0, pre1, tail, tok, tok_end;
  logic [7:0]              pre0_value, tail_len;
  logic                    fin, done, err;
  logic [1:0]              n_writes;
  logic [RES_CNT_BITS_L-1:0] cnt;
  logic [ADDRESS_BITS-1:0] step_len;

  assign cfg_ext   = EXT_BITS'(cfg_wdata_i);
  assign cfg_start = cfg_ext[ADDRESS_BITS-1:0];

  always_comb begin
    marker     = (block_length_q == srle_pkg::MARKER_LENGTH);
    raw        = (block_length_q >= srle_pkg::RAW_MIN);
    raw_total  = (block_length_q == srle_pkg::RAW_FULL) ? srle_pkg::RAW_FULL_COUNT
                                                        : block_length_q;
    consumed_d = consumed_q + 16'd1;
    at_end     = !marker && (consumed_d == block_length_q);

    pre0       = 1'b0;
    pre1       = 1'b0;
    pre0_value = 8'h00;
    tail       = 1'b0;
    tail_len   = 8'd1;
    tok        = 1'b0;
    tok_end    = 1'b0;
    phase_d    = phase_q;
    pending_d  = pending_q;
    fin        = 1'b0;
    done       = 1'b0;
    err        = 1'b0;

    case (phase_q)
      PH_Z: begin
        if (in_byte_i == srle_pkg::ESC_BYTE) begin
          phase_d = PH_Z_E;
        end else begin
          pre0 = 1'b1;
          tok  = 1'b1;
        end
      end
      PH_Z_E: begin
        if (in_byte_i == srle_pkg::ESC_BYTE) begin
          phase_d = PH_Z_E_E;
        end else begin
          pre0 = 1'b1;
          pre1 = 1'b1;
          tok  = 1'b1;
        end
      end
      PH_Z_E_E: begin
        if (in_byte_i == 8'h00) begin
          phase_d = PH_IDLE;
          fin     = 1'b1;
          done    = 1'b1;
        end else begin
          pre0      = 1'b1;
          pending_d = in_byte_i;
          phase_d   = PH_CNT;
        end
      end
      PH_E: begin
        if (in_byte_i == srle_pkg::ESC_BYTE) begin
          phase_d = PH_E_E;
        end else begin
          pre0       = 1'b1;
          pre0_value = srle_pkg::ESC_BYTE;
          tok        = 1'b1;
        end
      end
      PH_E_E: begin
        pending_d = in_byte_i;
        phase_d   = PH_CNT;
      end
      PH_CNT: begin
        tail     = (pending_q != 8'd0);
        tail_len = pending_q;
        phase_d  = PH_IDLE;
      end
      default: begin
        tok     = 1'b1;
        tok_end = at_end;
      end
    endcase

    // start of a new token
    if (tok) begin
      if (marker && in_byte_i == 8'h00) begin
        phase_d = PH_Z;
      end else if (in_byte_i == srle_pkg::ESC_BYTE && !tok_end) begin
        phase_d = PH_E;
      end else begin
        tail    = 1'b1;
        phase_d = PH_IDLE;
      end
    end

    if (raw) begin
      pre0      = 1'b0;
      pre1      = 1'b0;
      tail      = 1'b1;
      tail_len  = 8'd1;
      phase_d   = phase_q;
      pending_d = pending_q;
      fin       = (consumed_d >= raw_total);
      done      = fin;
    end else if (at_end && !fin) begin
      fin  = 1'b1;
      done = (phase_d == PH_IDLE);
      err  = (phase_d != PH_IDLE);
    end

    step_len    = ADDRESS_BITS'({1'b0, pre0} + {1'b0, pre1}) +
                  (tail ? ADDRESS_BITS'(tail_len) : '0);
    next_addr_d = next_addr_q + step_len;
    if (done && next_addr_d[PAGE_BITS-1:0] != '0) begin
      err = 1'b1;
    end

    n_writes = {1'b0, pre0} + {1'b0, pre1} + {1'b0, tail};
    if (halted_q) begin
      cnt = '0;
    end else if (n_writes == 2'd0 && fin) begin
      cnt = RES_CNT_BITS_L'(1);
    end else begin
      cnt = RES_CNT_BITS_L'(n_writes);
    end
  end

  always_comb begin
    res_cnt_o      = cnt;
    res_addr_o[0]  = next_addr_q;
    res_value_o[0] = pre0 ? pre0_value : (tail ? in_byte_i : 8'h00);
    res_len_o[0]   = pre0 ? 8'd1 : (tail ? tail_len : 8'd0);
    res_addr_o[1]  = next_addr_q + ADDRESS_BITS'(1);
    res_value_o[1] = pre1 ? srle_pkg::ESC_BYTE : in_byte_i;
    res_len_o[1]   = pre1 ? 8'd1 : tail_len;
    res_addr_o[2]  = next_addr_q + ADDRESS_BITS'(2);
    res_value_o[2] = in_byte_i;
    res_len_o[2]   = tail_len;
    for (int k = 0; k < srle_pkg::MAX_RESULTS; k++) begin
      res_flags_o[k].last = (cnt == RES_CNT_BITS_L'(k + 1));
      res_flags_o[k].done = (cnt == RES_CNT_BITS_L'(k + 1)) && done;
      res_flags_o[k].err  = (cnt == RES_CNT_BITS_L'(k + 1)) && err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q  <= '0;
      start_address_q <= '0;
      phase_q         <= PH_IDLE;
      next_addr_q     <= '0;
      consumed_q      <= '0;
      pending_q       <= '0;
      halted_q        <= 1'b0;
    end else if (cfg_we_i && (cfg_index_i == srle_pkg::REG_BLOCK_LENGTH ||
                              cfg_index_i == srle_pkg::REG_START_ADDRESS)) begin
      phase_q    <= PH_IDLE;
      consumed_q <= '0;
      pending_q  <= '0;
      halted_q   <= 1'b0;
      if (cfg_index_i == srle_pkg::REG_BLOCK_LENGTH) begin
        block_length_q <= cfg_wdata_i[15:0];
        next_addr_q    <= start_address_q;
      end else begin
        start_address_q <= cfg_start;
        next_addr_q     <= cfg_start;
      end
    end else if (step_i && !halted_q) begin
      phase_q     <= phase_d;
      next_addr_q <= next_addr_d;
      consumed_q  <= consumed_d;
      pending_q   <= pending_d;
      halted_q    <= fin;
    end
  end

endmodule

// ===== tb/srle_tb_pkg.sv =====
// srle_tb_pkg: write run record and scoreboard with its own decoder for the rle memory decoder
// depends on srle_pkg for register indexes, escape byte and block length codes
`timescale 1ns / 1ps

package srle_tb_pkg;
  import srle_pkg::*;

  localparam int unsigned RUN_ADDR_BITS   = 22;
  localparam int unsigned PAGE_ALIGN_BITS = 14;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_3 = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ZERO,
    PH_ZERO_ESC,
    PH_ZERO_ESC2,
    PH_ESC,
    PH_ESC2,
    PH_COUNT
  } decode_phase_e;

  typedef struct packed {
    logic [RUN_ADDR_BITS-1:0] address;
    logic [7:0]               value;
    logic [7:0]               length;
    logic                     done;
    logic                     err;
    logic                     last;
  } write_run_t;

  class rle_scoreboard;
    logic [15:0]              blk_len;
    logic [RUN_ADDR_BITS-1:0] first_addr;
    decode_phase_e            phase;
    logic [RUN_ADDR_BITS-1:0] next_addr;
    logic [15:0]              consumed;
    logic [7:0]               count;
    bit                       stopped;
    write_run_t               byte_runs[$];
    write_run_t               expected_runs[$];
    int unsigned              mismatches;
    int unsigned              bytes_decoded;

    function new();
      blk_len       = MARKER_LENGTH;
      first_addr    = '0;
      mismatches    = 0;
      bytes_decoded = 0;
      restart();
    endfunction

    function void restart();
      phase     = PH_IDLE;
      next_addr = first_addr;
      consumed  = '0;
      count     = '0;
      stopped   = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_BLOCK_LENGTH) begin
        blk_len = data[15:0];
      end else if (idx == REG_START_ADDRESS) begin
        first_addr = data[RUN_ADDR_BITS-1:0];
      end else begin
        return;
      end
      restart();
    endfunction

    function void emit(logic [7:0] value, logic [7:0] len);
      write_run_t r;
      if (len == 0 || byte_runs.size() >= MAX_RESULTS) return;
      r         = '0;
      r.address = next_addr;
      r.value   = value;
      r.length  = len;
      byte_runs.push_back(r);
      next_addr = next_addr + RUN_ADDR_BITS'(len);
    endfunction

    function void close_block(bit done, bit err);
      write_run_t r;
      bit         bad;
      bad = err || (done && next_addr[PAGE_ALIGN_BITS-1:0] != '0);
      if (byte_runs.size() == 0) begin
        r         = '0;
        r.address = next_addr;
        byte_runs.push_back(r);
      end
      r      = byte_runs.pop_back();
      r.done = done;
      r.err  = bad;
      byte_runs.push_back(r);
      stopped = 1'b1;
    endfunction

    function void start_token(logic [7:0] b, bit marker, bit at_end);
      if (marker && b == 8'h00) begin
        phase = PH_ZERO;
      end else if (b == ESC_BYTE && !at_end) begin
        phase = PH_ESC;
      end else begin
        emit(b, 8'd1);
        phase = PH_IDLE;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      bit          marker;
      bit          at_end;
      logic [16:0] total;
      write_run_t  r;
      byte_runs.delete();
      if (stopped) return;
      bytes_decoded++;
      consumed++;
      marker = (blk_len == MARKER_LENGTH);
      if (blk_len >= RAW_MIN) begin
        total = (blk_len == RAW_FULL) ? RAW_FULL_COUNT : blk_len;
        emit(b, 8'd1);
        if (consumed >= total) close_block(1'b1, 1'b0);
      end else begin
        at_end = !marker && consumed == blk_len;
        case (phase)
          PH_ZERO: begin
            if (b == ESC_BYTE) begin
              phase = PH_ZERO_ESC;
            end else begin
              emit(8'h00, 8'd1);
              start_token(b, marker, 1'b0);
            end
          end
          PH_ZERO_ESC: begin
            if (b == ESC_BYTE) begin
              phase = PH_ZERO_ESC2;
            end else begin
              emit(8'h00, 8'd1);
              emit(ESC_BYTE, 8'd1);
              start_token(b, marker, 1'b0);
            end
          end
          PH_ZERO_ESC2: begin
            if (b == 8'h00) begin
              phase = PH_IDLE;
              close_block(1'b1, 1'b0);
            end else begin
              emit(8'h00, 8'd1);
              count = b;
              phase = PH_COUNT;
            end
          end
          PH_ESC: begin
            if (b == ESC_BYTE) begin
              phase = PH_ESC2;
            end else begin
              emit(ESC_BYTE, 8'd1);
              start_token(b, marker, 1'b0);
            end
          end
          PH_ESC2: begin
            count = b;
            phase = PH_COUNT;
          end
          PH_COUNT: begin
            emit(b, count);
            phase = PH_IDLE;
          end
          default: start_token(b, marker, at_end);
        endcase
        if (at_end && !stopped) close_block(phase == PH_IDLE, phase != PH_IDLE);
      end
      if (byte_runs.size() > 0) begin
        r      = byte_runs.pop_back();
        r.last = 1'b1;
        byte_runs.push_back(r);
      end
      foreach (byte_runs[i]) expected_runs.push_back(byte_runs[i]);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %h got %h", $time, field, want, got);
    endfunction

    function void check_run(write_run_t got);
      write_run_t want;
      if (expected_runs.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected write run, expected none got addr %h value %h len %0d",
                 $time, got.address, got.value, got.length);
        return;
      end
      want = expected_runs.pop_front();
      if (got.address != want.address) report("write_address", want.address, got.address);
      if (got.value != want.value)     report("write_value", want.value, got.value);
      if (got.length != want.length)   report("run_length", want.length, got.length);
      if (got.done != want.done)       report("block_done", want.done, got.done);
      if (got.err != want.err)         report("format_error", want.err, got.err);
      if (got.last != want.last)       report("last_result", want.last, got.last);
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// tb_top: directed and random compressed byte streams into snapshot_rle_memory_decoder,
// write runs checked against the scoreboard in srle_tb_pkg
// depends on srle_pkg, srle_tb_pkg and the design sources
`timescale 1ns / 1ps

module tb_top;
  import srle_pkg::*;
  import srle_tb_pkg::*;

  localparam int unsigned STALL_PCT      = 9;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned RANDOM_BYTES   = 120;
  localparam int unsigned RAW_BYTES      = 40;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     cfg_we      = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata   = '0;
  logic                     in_valid    = 1'b0;
  logic                     in_stall;
  logic [7:0]               in_byte     = '0;
  logic                     out_valid;
  logic                     out_stall   = 1'b0;
  logic [RUN_ADDR_BITS-1:0] write_address;
  logic [7:0]               write_value;
  logic [7:0]               run_length;
  logic                     block_done;
  logic                     format_error;
  logic                     last_result;

  bit            no_idle = 1'b0;
  int unsigned   quiet_cycles = 0;
  logic [7:0]    stream[$];
  rle_scoreboard board = new();

  snapshot_rle_memory_decoder DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_byte_i      (in_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .write_address_o(write_address),
    .write_value_o  (write_value),
    .run_length_o   (run_length),
    .block_done_o   (block_done),
    .format_error_o (format_error),
    .last_result_o  (last_result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < STALL_PCT);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) board.write_reg(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) board.note_byte(in_byte);
      if (out_valid && !out_stall) begin
        board.check_run({write_address, write_value, run_length,
                         block_done, format_error, last_result});
      end
      if (cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!no_idle && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_stream();
    while (stream.size() > 0) send_byte(stream.pop_front());
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (board.expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data, input bit more);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (!more) cfg_we <= 1'b0;
  endtask

  task automatic run_block(input logic [15:0] len, input logic [RUN_ADDR_BITS-1:0] addr);
    logic [CFG_DATA_BITS-1:0] len_word;
    len_word = {($urandom_range(3) == 0) ? 6'($urandom) : 6'd0, len};
    if ($urandom_range(1) == 1) begin
      cfg_write(REG_BLOCK_LENGTH, len_word, 1'b1);
      cfg_write(REG_START_ADDRESS, addr, 1'b0);
    end else begin
      cfg_write(REG_START_ADDRESS, addr, 1'b1);
      cfg_write(REG_BLOCK_LENGTH, len_word, 1'b0);
    end
    send_stream();
    drain();
    // spare indexes must not wake a halted block
    if (board.stopped && $urandom_range(3) == 0) begin
      cfg_write(($urandom_range(1) == 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                CFG_DATA_BITS'($urandom), 1'b0);
      stream = {8'($urandom), 8'($urandom)};
      send_stream();
      drain();
    end
  endtask

  function automatic void add_token(bit marker);
    logic [7:0]  v;
    logic [7:0]  cnt;
    int unsigned pick;
    pick = $urandom_range(99);
    do v = 8'($urandom); while (v == ESC_BYTE || (marker && v == 8'h00));
    case ($urandom_range(9))
      0:       cnt = 8'h00;
      1:       cnt = 8'hFF;
      default: cnt = 8'($urandom_range(254, 1));
    endcase
    if (pick < 35) begin
      stream.push_back(v);
    end else if (pick < 65) begin
      stream = {stream, ESC_BYTE, ESC_BYTE, cnt, 8'($urandom)};
    end else if (pick < 75) begin
      stream = {stream, ESC_BYTE, v};
    end else if (pick < 85 && marker) begin
      stream = {stream, 8'h00, ESC_BYTE, ESC_BYTE, 8'($urandom_range(255, 1)), 8'($urandom)};
    end else if (pick < 92) begin
      stream = {stream, 8'h00, ESC_BYTE, v};
    end else begin
      stream = {stream, 8'h00, v};
    end
  endfunction

  function automatic logic [RUN_ADDR_BITS-1:0] pick_addr();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return {8'($urandom), {PAGE_ALIGN_BITS{1'b0}}};
      3:       return 22'h3FFFFF - 22'($urandom_range(40));
      default: return RUN_ADDR_BITS'($urandom);
    endcase
  endfunction

  function automatic void add_trailing();
    repeat ($urandom_range(2)) stream.push_back(8'($urandom));
  endfunction

  initial begin
    int unsigned kind;
    int unsigned cut;
    int unsigned len;
    int unsigned target;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers still at reset: marker ended block at address zero
    stream = {8'h41, 8'hFF, ESC_BYTE, 8'h05, ESC_BYTE, ESC_BYTE, 8'h03, 8'hAA,
              ESC_BYTE, ESC_BYTE, 8'h00, 8'h77, 8'h00, ESC_BYTE, ESC_BYTE, 8'h02, 8'h55,
              8'h00, ESC_BYTE, 8'h11, 8'h00, ESC_BYTE, ESC_BYTE, 8'h00, 8'h99};
    send_stream();
    drain();

    // single byte block ending on an escape byte, address wraps to aligned zero
    stream = {ESC_BYTE};
    run_block(16'd1, 22'h3FFFFF);

    repeat (6) add_token(1'b0);
    run_block(16'hBFFF, pick_addr());

    repeat (20) stream.push_back(8'($urandom));
    run_block(16'hFFFE, '0);

    no_idle = 1'b1;
    repeat (RAW_BYTES) stream.push_back(8'($urandom));
    run_block(RAW_FULL, {8'($urandom), {PAGE_ALIGN_BITS{1'b0}}});

    repeat (RAW_BYTES) stream.push_back(8'($urandom));
    run_block(RAW_MIN, 22'h3FF123);
    no_idle = 1'b0;

    target = board.bytes_decoded + RANDOM_BYTES;
    while (board.bytes_decoded < target) begin
      kind = $urandom_range(9);
      stream.delete();
      if (kind < 3) begin
        repeat ($urandom_range(12, 3)) add_token(1'b1);
        stream = {stream, 8'h00, ESC_BYTE, ESC_BYTE, 8'h00};
        add_trailing();
        run_block(MARKER_LENGTH, pick_addr());
      end else if (kind < 5) begin
        repeat ($urandom_range(10, 2)) add_token(1'b0);
        if ($urandom_range(2) == 0) stream.push_back(ESC_BYTE);
        len = stream.size();
        add_trailing();
        run_block(16'(len), pick_addr());
      end else if (kind < 7) begin
        repeat ($urandom_range(10, 2)) add_token(1'b0);
        cut = $urandom_range(3, 1);
        if (cut >= stream.size()) cut = stream.size() - 1;
        run_block(16'(stream.size() - cut), pick_addr());
      end else if (kind == 7) begin
        repeat ($urandom_range(8, 2)) add_token(1'b0);
        len = ($urandom_range(3) == 0) ? 32'hBFFF
            : stream.size() + $urandom_range(32'hBFFF - stream.size(), 1);
        run_block(16'(len), pick_addr());
      end else if (kind == 8) begin
        repeat ($urandom_range(30, 3)) stream.push_back(8'($urandom));
        run_block(16'($urandom_range(RAW_FULL, RAW_MIN)), pick_addr());
      end else begin
        repeat ($urandom_range(30, 5)) begin
          case ($urandom_range(3))
            0:       stream.push_back(8'h00);
            1:       stream.push_back(ESC_BYTE);
            default: stream.push_back(8'($urandom));
          endcase
        end
        len = ($urandom_range(1) == 1) ? 0 : $urandom_range(40, 1);
        run_block(16'(len), pick_addr());
      end
    end

    if (board.mismatches == 0 && board.expected_runs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
